/* hw/rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int CntW = 16;
	localparam int SBlinkW = 15;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SHORT_PRESS = 2'd0,
		REG_LONG_PRESS  = 2'd1,
		REG_SHORT_BLINK = 2'd2,
		REG_LONG_BLINK  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_TOGGLE = 2'd1,
		ACT_IGNORE = 2'd2
	} action_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_ON1    = 4'b0010,
		PH_OFF    = 4'b0100,
		PH_ON2    = 4'b1000
	} phase_t;

	localparam logic [CntW-1:0]    RstShortPress = 16'd50;
	localparam logic [CntW-1:0]    RstLongPress  = 16'd700;
	localparam logic [SBlinkW-1:0] RstShortBlink = 15'd300;
	localparam logic [CntW-1:0]    RstLongBlink  = 16'd1000;
	localparam logic [CntW-1:0]    CntMax        = 16'hFFFF;

	typedef struct packed {
		logic [CntW-1:0]    short_press;
		logic [CntW-1:0]    long_press;
		logic [SBlinkW-1:0] short_blink;
		logic [CntW-1:0]    long_blink;
	} cfg_t;

	typedef struct packed {
		logic    led_on;
		logic    available;
		action_t action;
	} result_t;

	typedef struct packed {
		logic            press_timing;
		logic [CntW-1:0] press_elapsed;
		logic            short_pending;
		logic            long_pending;
		logic            feedback_done;
		phase_t          sb_phase;
		logic [CntW-1:0] sb_elapsed;
		logic            lb_active;
		logic [CntW-1:0] lb_elapsed;
		logic            led;
	} state_t;

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (v == CntMax) ? v : v + 16'd1;
	endfunction

endpackage

/* hw/rtl/button_press_classifier_with_blink_top.sv */
// ----------------------------------------------------------------------------
// button_press_classifier_with_blink_top
// Button short/long press classifier with LED blink feedback.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one item per transfer: op selects a
// one millisecond tick (button_low sampled) or a fetch of the pending action.
// Output channel (out_valid/out_stall) returns exactly one result per item:
// led_on, available and action.
// The result of an accepted item goes to the output register and is shown in
// out_valid from the next cycle on. Throughput is one item per cycle while
// in_stall is low; the state update is a single pass of counters and compares
// into the state registers, and the result goes to one output register.
// When the receiver stalls, the result holds in the output register and
// in_stall rises as long as that register is full and stalled.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle; write only while no item is in flight.
// Reset clears all press and blink state, empties the output register and
// loads the default limits.
// ----------------------------------------------------------------------------
module button_press_classifier_with_blink_top
	import bpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic                button_low,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                led_on,
	output logic                available,
	output logic [1:0]          action,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.button_low (button_low),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign led_on = res_q.led_on;
	assign available = res_q.available;
	assign action = res_q.action;

endmodule

/* hw/rtl/bpc_cfg.sv */
// ----------------------------------------------------------------------------
// bpc_cfg
// Configuration registers for press limits and blink lengths.
// ----------------------------------------------------------------------------
module bpc_cfg
	import bpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press <= RstShortPress;
			cfg_q.long_press  <= RstLongPress;
			cfg_q.short_blink <= RstShortBlink;
			cfg_q.long_blink  <= RstLongBlink;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SHORT_PRESS: cfg_q.short_press <= cfg_data;
				REG_LONG_PRESS:  cfg_q.long_press  <= cfg_data;
				REG_SHORT_BLINK: cfg_q.short_blink <= cfg_data[SBlinkW-1:0];
				REG_LONG_BLINK:  cfg_q.long_blink  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/bpc_core.sv */
// ----------------------------------------------------------------------------
// bpc_core
// Press timing, classification and LED sequence state with its update logic.
// ----------------------------------------------------------------------------
module bpc_core
	import bpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  logic    op,
	input  logic    button_low,
	input  cfg_t    cfg,
	output result_t res
);

	state_t st_q;
	state_t nx;
	action_t act;
	logic [CntW:0] s1, s2, s3;
	logic done;

	assign s1 = {2'b00, cfg.short_blink};
	assign s2 = {1'b0, cfg.short_blink, 1'b0};
	assign s3 = s1 + s2;

	always_comb begin
		nx = st_q;
		act = ACT_NONE;
		done = 1'b0;
		if (op_t'(op) == OP_FETCH) begin
			if (st_q.short_pending) begin
				act = ACT_TOGGLE;
			end else if (st_q.long_pending) begin
				act = ACT_IGNORE;
			end
			nx.short_pending = 1'b0;
			nx.long_pending = 1'b0;
		end else begin
			if (nx.sb_phase != PH_IDLE) nx.sb_elapsed = sat_inc(nx.sb_elapsed);
			if (nx.lb_active) nx.lb_elapsed = sat_inc(nx.lb_elapsed);
			if (nx.press_timing) nx.press_elapsed = sat_inc(nx.press_elapsed);

			if (button_low) begin
				if (!nx.press_timing) begin
					nx.press_timing = 1'b1;
					nx.press_elapsed = '0;
					nx.feedback_done = 1'b0;
				end
			end else if (nx.press_timing) begin
				if (nx.press_elapsed > cfg.long_press) begin
					nx.long_pending = 1'b1;
				end else if (nx.press_elapsed > cfg.short_press) begin
					nx.short_pending = 1'b1;
				end
				nx.press_timing = 1'b0;
				nx.press_elapsed = '0;
			end

			if (nx.short_pending && !nx.feedback_done) begin
				if (nx.sb_phase == PH_IDLE) begin
					nx.sb_phase = PH_ON1;
					nx.sb_elapsed = '0;
					nx.led = 1'b1;
				end
				if (nx.sb_phase == PH_ON1 && {1'b0, nx.sb_elapsed} > s1) begin
					nx.led = 1'b0;
					nx.sb_phase = PH_OFF;
				end
				if (nx.sb_phase == PH_OFF && {1'b0, nx.sb_elapsed} > s2) begin
					nx.led = 1'b1;
					nx.sb_phase = PH_ON2;
				end
				if (nx.sb_phase == PH_ON2 && {1'b0, nx.sb_elapsed} > s3) begin
					nx.led = 1'b0;
					nx.sb_phase = PH_IDLE;
					nx.sb_elapsed = '0;
					done = 1'b1;
				end
				nx.feedback_done = done;
			end

			if (nx.long_pending && !nx.feedback_done) begin
				if (!nx.lb_active) begin
					nx.lb_active = 1'b1;
					nx.lb_elapsed = '0;
					nx.led = 1'b1;
				end
				nx.feedback_done = 1'b0;
				if (nx.lb_elapsed > cfg.long_blink) begin
					nx.lb_active = 1'b0;
					nx.lb_elapsed = '0;
					nx.led = 1'b0;
					nx.feedback_done = 1'b1;
				end
			end
		end
		res.led_on = nx.led;
		res.available = (nx.short_pending || nx.long_pending) && nx.feedback_done;
		res.action = act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{press_timing: 1'b0, press_elapsed: '0, short_pending: 1'b0,
				long_pending: 1'b0, feedback_done: 1'b0, sb_phase: PH_IDLE,
				sb_elapsed: '0, lb_active: 1'b0, lb_elapsed: '0, led: 1'b0};
		end else if (accept) begin
			st_q <= nx;
		end
	end

endmodule

/* hw/rtl/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the button press classifier, bound to its top level.
// ----------------------------------------------------------------------------
module bpc_checker
	import bpc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                op,
	input logic                out_valid,
	input logic                out_stall,
	input logic                led_on,
	input logic                available,
	input logic [1:0]          action
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_on)
			&& $stable(available) && $stable(action))
		else $error("stalled result changed");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_TICK |=> out_valid && action == ACT_NONE)
		else $error("tick transfer gave no result or a nonzero action");

	a_fetch_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_FETCH |=> out_valid)
		else $error("fetch transfer gave no result");

	a_fetch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_TOGGLE || action == ACT_IGNORE) |-> !available)
		else $error("action returned while press still pending");

endmodule

bind button_press_classifier_with_blink_top bpc_checker u_bpc_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button press classifier with LED blink feedback.
// Drives tick and fetch items over the valid/stall channel and predicts every
// result (LED drive, available flag, action) with its own model of press
// timing, classification and blink sequences. The run covers directed corner
// sequences and random press sequences under several limit settings and
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
	import bpc_pkg::*;

	class press_predictor;
		logic [CntW-1:0]    lim_short;
		logic [CntW-1:0]    lim_long;
		logic [SBlinkW-1:0] blink_short;
		logic [CntW-1:0]    blink_long;

		bit                 timing;
		logic [CntW-1:0]    press_cnt;
		bit                 short_pend;
		bit                 long_pend;
		bit                 fb_done;
		phase_t             dbl_phase;
		logic [CntW-1:0]    dbl_cnt;
		bit                 hold_act;
		logic [CntW-1:0]    hold_cnt;
		bit                 led;

		result_t            due_q[$];
		int                 errors;
		int                 n_checked;
		int                 n_short;
		int                 n_long;
		int                 n_actions;

		function new();
			lim_short   = RstShortPress;
			lim_long    = RstLongPress;
			blink_short = RstShortBlink;
			blink_long  = RstLongBlink;
			timing      = 1'b0;
			press_cnt   = '0;
			short_pend  = 1'b0;
			long_pend   = 1'b0;
			fb_done     = 1'b0;
			dbl_phase   = PH_IDLE;
			dbl_cnt     = '0;
			hold_act    = 1'b0;
			hold_cnt    = '0;
			led         = 1'b0;
			errors      = 0;
			n_checked   = 0;
			n_short     = 0;
			n_long      = 0;
			n_actions   = 0;
		endfunction

		function void write_cfg(reg_idx_t idx, logic [CfgDataW-1:0] d);
			case (idx)
				REG_SHORT_PRESS: lim_short = d;
				REG_LONG_PRESS:  lim_long = d;
				REG_SHORT_BLINK: blink_short = d[SBlinkW-1:0];
				REG_LONG_BLINK:  blink_long = d;
				default: ;
			endcase
		endfunction

		function logic [CntW-1:0] bump(logic [CntW-1:0] v);
			return (v == CntMax) ? v : v + 1'b1;
		endfunction

		function bit step_double_blink();
			int unsigned s;
			int unsigned e;
			s = blink_short;
			if (dbl_phase == PH_IDLE) begin
				dbl_phase = PH_ON1;
				dbl_cnt = '0;
				led = 1'b1;
			end
			e = dbl_cnt;
			if (dbl_phase == PH_ON1 && e > s) begin
				led = 1'b0;
				dbl_phase = PH_OFF;
			end
			if (dbl_phase == PH_OFF && e > 2 * s) begin
				led = 1'b1;
				dbl_phase = PH_ON2;
			end
			if (dbl_phase == PH_ON2 && e > 3 * s) begin
				led = 1'b0;
				dbl_phase = PH_IDLE;
				dbl_cnt = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit step_hold();
			if (!hold_act) begin
				hold_act = 1'b1;
				hold_cnt = '0;
				led = 1'b1;
			end
			if (hold_cnt > blink_long) begin
				hold_act = 1'b0;
				hold_cnt = '0;
				led = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(op_t o, logic pressed);
			result_t r;
			r.action = ACT_NONE;
			if (o == OP_FETCH) begin
				if (short_pend)
					r.action = ACT_TOGGLE;
				else if (long_pend)
					r.action = ACT_IGNORE;
				short_pend = 1'b0;
				long_pend = 1'b0;
			end else begin
				if (dbl_phase != PH_IDLE)
					dbl_cnt = bump(dbl_cnt);
				if (hold_act)
					hold_cnt = bump(hold_cnt);
				if (timing)
					press_cnt = bump(press_cnt);
				if (pressed) begin
					if (!timing) begin
						timing = 1'b1;
						press_cnt = '0;
						fb_done = 1'b0;
					end
				end else if (timing) begin
					if (press_cnt > lim_long) begin
						long_pend = 1'b1;
						n_long++;
					end else if (press_cnt > lim_short) begin
						short_pend = 1'b1;
						n_short++;
					end
					timing = 1'b0;
					press_cnt = '0;
				end
				if (short_pend && !fb_done)
					fb_done = step_double_blink();
				if (long_pend && !fb_done)
					fb_done = step_hold();
			end
			r.led_on = led;
			r.available = (short_pend || long_pend) && fb_done;
			due_q.push_back(r);
		endfunction

		function void check_result(logic l, logic a, logic [1:0] act);
			result_t w;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result led_on=%0b available=%0b action=%0d",
					$time, l, a, act);
				return;
			end
			w = due_q.pop_front();
			n_checked++;
			if (act != ACT_NONE)
				n_actions++;
			if (l !== w.led_on) begin
				errors++;
				$display("%0t: led_on expected %0b actual %0b", $time, w.led_on, l);
			end
			if (a !== w.available) begin
				errors++;
				$display("%0t: available expected %0b actual %0b", $time, w.available, a);
			end
			if (act !== w.action) begin
				errors++;
				$display("%0t: action expected %0d actual %0d", $time, w.action, act);
			end
		endfunction
	endclass

	localparam int QuietLimit = 4000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = 1'b0;
	logic                button_low = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                led_on;
	logic                available;
	logic [1:0]          action;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	press_predictor sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int n_sent = 0;
	int n_settings = 0;
	int quiet_cycles = 0;

	button_press_classifier_with_blink_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.button_low(button_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_on(led_on),
		.available(available),
		.action(action),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(op_t'(op), button_low);
			if (out_valid && !out_stall)
				sb.check_result(led_on, available, action);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_item(input op_t o, input logic b);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		button_low <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic press_for(input int n);
		for (int i = 0; i < n; i++)
			send_item(OP_TICK, 1'b1);
	endtask

	task automatic idle_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_item(OP_TICK, 1'b0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic load_limits(input logic [CfgDataW-1:0] sp, input logic [CfgDataW-1:0] lp,
			input logic [CfgDataW-1:0] sbk, input logic [CfgDataW-1:0] lb);
		logic [CfgDataW-1:0] vals[4];
		vals[0] = sp;
		vals[1] = lp;
		vals[2] = sbk;
		vals[3] = lb;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_cfg(reg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [CfgDataW-1:0] pick_limit(input int hi,
			input logic [CfgDataW-1:0] top);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return top;
		return CfgDataW'($urandom_range(0, hi));
	endfunction

	task automatic run_press();
		int hold;
		int gap;
		int cap;
		case ($urandom_range(0, 5))
			0: hold = int'(sb.lim_short);
			1: hold = int'(sb.lim_short) + 1;
			2: hold = int'(sb.lim_short) + 2;
			3: hold = int'(sb.lim_long);
			4: hold = int'(sb.lim_long) + $urandom_range(1, 2);
			default: hold = $urandom_range(0, int'(sb.lim_long) + 3);
		endcase
		if (hold > 60)
			hold = $urandom_range(1, 60);
		press_for(hold);
		cap = 3 * int'(sb.blink_short) + int'(sb.blink_long) + 6;
		if (cap > 80)
			cap = 80;
		gap = $urandom_range(1, cap);
		for (int i = 0; i < gap; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(OP_FETCH, 1'($urandom_range(0, 1)));
			else
				send_item(OP_TICK, 1'b0);
		end
		if ($urandom_range(0, 9) < 7)
			send_item(OP_FETCH, 1'($urandom_range(0, 1)));
	endtask

	task automatic noise();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			send_item(op_t'(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_FETCH, 1'b1);
		send_item(OP_TICK, 1'b0);
		settle();
		load_limits(16'd2, 16'd5, 16'd1, 16'd2);
		press_for(2);
		idle_ticks(1);
		press_for(3);
		idle_ticks(2);
		send_item(OP_FETCH, 1'b0);
		idle_ticks(2);
		press_for(6);
		idle_ticks(2);
		press_for(1);
		idle_ticks(4);
		press_for(3);
		idle_ticks(3);
		send_item(OP_FETCH, 1'b1);
		send_item(OP_FETCH, 1'b0);

		n_sent = 0;
		for (int p = 0; p < 8; p++) begin
			settle();
			if (p == 0)
				load_limits('0, '0, '0, '0);
			else
				load_limits(pick_limit(8, CntMax), pick_limit(14, CntMax),
					pick_limit(6, 16'd21845), pick_limit(15, CntMax));
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 85;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 85;
				end
				default: begin
					idle_pct = 11;
					stall_pct = 11;
				end
			endcase
			target = (p + 1) * 160;
			while (n_sent < target) begin
				if ($urandom_range(0, 99) < 75)
					run_press();
				else
					noise();
			end
		end
		settle();

		if (sb.due_q.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.due_q.size());
		end
		$display("Checked %0d results across %0d limit settings and four idle/stall mixes.",
			sb.n_checked, n_settings);
		$display("Presses classified: %0d short, %0d long; %0d fetches returned an action.",
			sb.n_short, sb.n_long, sb.n_actions);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_cfg.sv
hw/rtl/bpc_core.sv
hw/rtl/button_press_classifier_with_blink_top.sv
hw/rtl/bpc_checker.sv
tb/tb.sv
